@@ rtl/thst_pkg.sv @@
package thst_pkg;

  localparam logic [1:0] FUNC_PUBLISH     = 2'd0;
  localparam logic [1:0] FUNC_SUBSCRIBE   = 2'd1;
  localparam logic [1:0] FUNC_UNSUBSCRIBE = 2'd2;
  localparam logic [1:0] FUNC_COUNT       = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
  localparam logic [2:0] ST_ALREADY_SUB = 3'd3;
  localparam logic [2:0] ST_NOT_SUB     = 3'd4;
  localparam logic [2:0] ST_LIST_FULL   = 3'd5;
  localparam logic [2:0] ST_KEY_LONG    = 3'd6;

  localparam int          HASH_W    = 32;
  localparam logic [31:0] HASH_SEED = 32'd5381;

endpackage

@@ rtl/thst_ram.sv @@
module thst_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/topic_hash_subscription_table_unit.sv @@
// Topic subscription table with djb2 hashing and linear probing.
// The input channel carries one key byte per request; the request with
// key_last_i set closes the key and carries the operation and the port.
// Requests that do not close the key only extend the key.
// A closing request starts a sequencer that probes the slot table from the
// home slot, reading each probed slot's length and comparing the key byte by
// byte, then searches or shifts the subscriber list one entry at a time.
// A subscribe that creates a topic copies the key byte by byte into its slot.
// A publish reads the subscriber list in order and registers each port as a result.
// A closing request with an overlong key goes straight to its result, and the
// input channel is not ready until the last result has been registered.
// Every closing request gives one result, except a publish to a topic with
// subscribers, which gives one result per subscriber in list order, the
// final one marked by last_o.
// The result sits in an output register; while the receiver stalls, the
// sequencer holds before registering the next result.
// Reset empties the table and the key accumulator at once; the key and
// port memories need no clearing. TABLE_SLOTS must be a power of two.
module topic_hash_subscription_table_unit #(
  parameter int TABLE_SLOTS    = 64,
  parameter int KEY_BYTES      = 63,
  parameter int SUBS_PER_TOPIC = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  input  logic [15:0] port_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        port_valid_o,
  output logic [15:0] sub_port_o,
  output logic [3:0]  sub_count_o,
  output logic [5:0]  slot_o,
  output logic        last_o
);
  import thst_pkg::*;

  localparam int SL_W   = $clog2(TABLE_SLOTS);
  localparam int N_W    = $clog2(TABLE_SLOTS + 1);
  localparam int LEN_W  = $clog2(KEY_BYTES + 2);
  localparam int CNT_W  = $clog2(SUBS_PER_TOPIC + 1);
  localparam int KB_AW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KA_D   = TABLE_SLOTS * KEY_BYTES;
  localparam int KA_W   = $clog2(KA_D);
  localparam int PA_D   = TABLE_SLOTS * SUBS_PER_TOPIC;
  localparam int PA_W   = $clog2(PA_D);
  localparam int META_W = LEN_W + CNT_W;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PROBE   = 5'd1;
  localparam logic [4:0] S_META    = 5'd2;
  localparam logic [4:0] S_CMP_RD  = 5'd3;
  localparam logic [4:0] S_CMP_CHK = 5'd4;
  localparam logic [4:0] S_OP      = 5'd5;
  localparam logic [4:0] S_SRCH_RD = 5'd6;
  localparam logic [4:0] S_SRCH_CK = 5'd7;
  localparam logic [4:0] S_SH_RD   = 5'd8;
  localparam logic [4:0] S_SH_WR   = 5'd9;
  localparam logic [4:0] S_PUB_RD  = 5'd10;
  localparam logic [4:0] S_PUB_WT  = 5'd11;
  localparam logic [4:0] S_CP_RD   = 5'd12;
  localparam logic [4:0] S_CP_WR   = 5'd13;
  localparam logic [4:0] S_EMIT    = 5'd14;

  logic [4:0]             state_q, state_d;
  logic [HASH_W-1:0]      hash_q, hash_d, hash_next;
  logic [LEN_W-1:0]       kcnt_q, kcnt_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [1:0]             func_q, func_d;
  logic [15:0]            port_q, port_d;
  logic [SL_W-1:0]        slot_q, slot_d;
  logic [N_W-1:0]         n_q, n_d;
  logic [N_W-1:0]         total_q, total_d;
  logic [LEN_W-1:0]       byte_q, byte_d;
  logic [CNT_W-1:0]       pi_q, pi_d;
  logic [CNT_W-1:0]       c_q, c_d;
  logic [TABLE_SLOTS-1:0] used_q, used_d;

  logic [2:0]       r_status_q, r_status_d;
  logic             r_pv_q, r_pv_d;
  logic [15:0]      r_port_q, r_port_d;
  logic [CNT_W-1:0] r_cnt_q, r_cnt_d;
  logic [SL_W-1:0]  r_slot_q, r_slot_d;
  logic             r_last_q, r_last_d;

  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_status_q, out_status_d;
  logic             out_pv_q, out_pv_d;
  logic [15:0]      out_port_q, out_port_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [SL_W-1:0]  out_slot_q, out_slot_d;
  logic             out_last_q, out_last_d;

  logic             kb_we, kb_re;
  logic [KB_AW-1:0] kb_waddr, kb_raddr;
  logic [7:0]       kb_rdata;
  logic             key_we, key_re;
  logic [KA_W-1:0]  key_addr;
  logic [7:0]       key_rdata;
  logic             meta_we, meta_re;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic             pt_we, pt_re;
  logic [PA_W-1:0]  pt_waddr, pt_raddr;
  logic [15:0]      pt_wdata, pt_rdata;
  logic [CNT_W-1:0] pt_widx, pt_ridx;

  logic             accept, out_free;
  logic [CNT_W-1:0] pi_inc;
  logic [SL_W+5:0]  slot_wide;
  logic [CNT_W+3:0] cnt_wide;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || out_ready_i;
  assign hash_next = (hash_q << 5) + hash_q + HASH_W'(key_byte_i);
  assign pi_inc    = pi_q + CNT_W'(1);

  assign kb_waddr = KB_AW'(kcnt_q);
  assign kb_raddr = KB_AW'(byte_q);
  assign key_addr = KA_W'(KA_W'(slot_q) * KA_W'(KEY_BYTES) + KA_W'(byte_q));
  assign pt_waddr = PA_W'(PA_W'(slot_q) * PA_W'(SUBS_PER_TOPIC) + PA_W'(pt_widx));
  assign pt_raddr = PA_W'(PA_W'(slot_q) * PA_W'(SUBS_PER_TOPIC) + PA_W'(pt_ridx));

  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    kcnt_d      = kcnt_q;
    len_d       = len_q;
    func_d      = func_q;
    port_d      = port_q;
    slot_d      = slot_q;
    n_d         = n_q;
    total_d     = total_q;
    byte_d      = byte_q;
    pi_d        = pi_q;
    c_d         = c_q;
    used_d      = used_q;
    r_status_d  = r_status_q;
    r_pv_d      = r_pv_q;
    r_port_d    = r_port_q;
    r_cnt_d     = r_cnt_q;
    r_slot_d    = r_slot_q;
    r_last_d    = r_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_pv_d    = out_pv_q;
    out_port_d  = out_port_q;
    out_cnt_d   = out_cnt_q;
    out_slot_d  = out_slot_q;
    out_last_d  = out_last_q;
    kb_we       = 1'b0;
    kb_re       = 1'b0;
    key_we      = 1'b0;
    key_re      = 1'b0;
    meta_we     = 1'b0;
    meta_re     = 1'b0;
    meta_wdata  = {len_q, c_q};
    pt_we       = 1'b0;
    pt_re       = 1'b0;
    pt_wdata    = port_q;
    pt_widx     = pi_q;
    pt_ridx     = pi_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kcnt_q < LEN_W'(KEY_BYTES)) begin
            kb_we  = 1'b1;
            hash_d = hash_next;
            kcnt_d = kcnt_q + LEN_W'(1);
          end else begin
            kcnt_d = LEN_W'(KEY_BYTES + 1);
          end
          if (key_last_i) begin
            func_d = func_i;
            port_d = port_i;
            len_d  = kcnt_d;
            slot_d = hash_d[SL_W-1:0];
            n_d    = '0;
            hash_d = HASH_SEED;
            kcnt_d = '0;
            r_pv_d   = 1'b0;
            r_port_d = '0;
            r_last_d = 1'b1;
            if (kcnt_q >= LEN_W'(KEY_BYTES)) begin
              r_status_d = ST_KEY_LONG;
              r_cnt_d    = '0;
              r_slot_d   = '0;
              state_d    = S_EMIT;
            end else begin
              state_d = S_PROBE;
            end
          end
        end
      end
      S_PROBE: begin
        r_cnt_d  = '0;
        r_slot_d = '0;
        if (n_q == N_W'(TABLE_SLOTS) || !used_q[slot_q]) begin
          if (func_q != FUNC_SUBSCRIBE) begin
            r_status_d = ST_NOT_FOUND;
            state_d    = S_EMIT;
          end else if (n_q == N_W'(TABLE_SLOTS) || total_q >= N_W'(TABLE_SLOTS)) begin
            r_status_d = ST_TABLE_FULL;
            state_d    = S_EMIT;
          end else begin
            used_d[slot_q] = 1'b1;
            total_d    = total_q + N_W'(1);
            meta_we    = 1'b1;
            meta_wdata = {len_q, CNT_W'(1)};
            pt_we      = 1'b1;
            pt_widx    = '0;
            byte_d     = '0;
            r_status_d = ST_OK;
            r_cnt_d    = CNT_W'(1);
            r_slot_d   = slot_q;
            state_d    = S_CP_RD;
          end
        end else begin
          meta_re = 1'b1;
          state_d = S_META;
        end
      end
      S_META: begin
        byte_d = '0;
        c_d    = meta_rdata[CNT_W-1:0];
        if (meta_rdata[META_W-1:CNT_W] == len_q) begin
          state_d = S_CMP_RD;
        end else begin
          slot_d  = slot_q + SL_W'(1);
          n_d     = n_q + N_W'(1);
          state_d = S_PROBE;
        end
      end
      S_CMP_RD: begin
        if (byte_q == len_q) begin
          state_d = S_OP;
        end else begin
          kb_re   = 1'b1;
          key_re  = 1'b1;
          state_d = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (kb_rdata == key_rdata) begin
          byte_d  = byte_q + LEN_W'(1);
          state_d = S_CMP_RD;
        end else begin
          slot_d  = slot_q + SL_W'(1);
          n_d     = n_q + N_W'(1);
          state_d = S_PROBE;
        end
      end
      S_OP: begin
        pi_d       = '0;
        r_status_d = ST_OK;
        r_cnt_d    = c_q;
        r_slot_d   = slot_q;
        unique case (func_q) inside
          FUNC_SUBSCRIBE, FUNC_UNSUBSCRIBE: state_d = S_SRCH_RD;
          FUNC_COUNT: state_d = S_EMIT;
          default: begin
            state_d = (c_q == '0) ? S_EMIT : S_PUB_RD;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (pi_q == c_q) begin
          if (func_q == FUNC_UNSUBSCRIBE) begin
            r_status_d = ST_NOT_SUB;
          end else if (c_q >= CNT_W'(SUBS_PER_TOPIC)) begin
            r_status_d = ST_LIST_FULL;
          end else begin
            pt_we      = 1'b1;
            pt_widx    = c_q;
            meta_we    = 1'b1;
            meta_wdata = {len_q, c_q + CNT_W'(1)};
            r_cnt_d    = c_q + CNT_W'(1);
          end
          state_d = S_EMIT;
        end else begin
          pt_re   = 1'b1;
          state_d = S_SRCH_CK;
        end
      end
      S_SRCH_CK: begin
        if (pt_rdata == port_q) begin
          if (func_q == FUNC_SUBSCRIBE) begin
            r_status_d = ST_ALREADY_SUB;
            state_d    = S_EMIT;
          end else begin
            state_d = S_SH_RD;
          end
        end else begin
          pi_d    = pi_inc;
          state_d = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        if (pi_inc == c_q) begin
          meta_we    = 1'b1;
          meta_wdata = {len_q, c_q - CNT_W'(1)};
          r_cnt_d    = c_q - CNT_W'(1);
          state_d    = S_EMIT;
        end else begin
          pt_re   = 1'b1;
          pt_ridx = pi_inc;
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        pt_we    = 1'b1;
        pt_wdata = pt_rdata;
        pi_d     = pi_inc;
        state_d  = S_SH_RD;
      end
      S_PUB_RD: begin
        pt_re   = 1'b1;
        state_d = S_PUB_WT;
      end
      S_PUB_WT: begin
        r_pv_d   = 1'b1;
        r_port_d = pt_rdata;
        r_last_d = (pi_inc == c_q);
        pi_d     = pi_inc;
        state_d  = S_EMIT;
      end
      S_CP_RD: begin
        if (byte_q == len_q) begin
          state_d = S_EMIT;
        end else begin
          kb_re   = 1'b1;
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        key_we  = 1'b1;
        byte_d  = byte_q + LEN_W'(1);
        state_d = S_CP_RD;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = r_status_q;
          out_pv_d     = r_pv_q;
          out_port_d   = r_port_q;
          out_cnt_d    = r_cnt_q;
          out_slot_d   = r_slot_q;
          out_last_d   = r_last_q;
          state_d      = r_last_q ? S_IDLE : S_PUB_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hash_q      <= HASH_SEED;
      kcnt_q      <= '0;
      total_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      kcnt_q      <= kcnt_d;
      total_q     <= total_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    func_q       <= func_d;
    port_q       <= port_d;
    slot_q       <= slot_d;
    n_q          <= n_d;
    byte_q       <= byte_d;
    pi_q         <= pi_d;
    c_q          <= c_d;
    r_status_q   <= r_status_d;
    r_pv_q       <= r_pv_d;
    r_port_q     <= r_port_d;
    r_cnt_q      <= r_cnt_d;
    r_slot_q     <= r_slot_d;
    r_last_q     <= r_last_d;
    out_status_q <= out_status_d;
    out_pv_q     <= out_pv_d;
    out_port_q   <= out_port_d;
    out_cnt_q    <= out_cnt_d;
    out_slot_q   <= out_slot_d;
    out_last_q   <= out_last_d;
  end

  thst_ram #(.W(8), .DEPTH(KEY_BYTES)) u_key_buf (
    .clk_i   (clk_i),
    .we_i    (kb_we),
    .waddr_i (kb_waddr),
    .wdata_i (key_byte_i),
    .re_i    (kb_re),
    .raddr_i (kb_raddr),
    .rdata_o (kb_rdata)
  );

  thst_ram #(.W(8), .DEPTH(KA_D)) u_key_store (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_addr),
    .wdata_i (kb_rdata),
    .re_i    (key_re),
    .raddr_i (key_addr),
    .rdata_o (key_rdata)
  );

  thst_ram #(.W(META_W), .DEPTH(TABLE_SLOTS)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (slot_q),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (slot_q),
    .rdata_o (meta_rdata)
  );

  thst_ram #(.W(16), .DEPTH(PA_D)) u_ports (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  assign slot_wide = (SL_W + 6)'(out_slot_q);
  assign cnt_wide  = (CNT_W + 4)'(out_cnt_q);

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign port_valid_o = out_pv_q;
  assign sub_port_o   = out_port_q;
  assign sub_count_o  = cnt_wide[3:0];
  assign slot_o       = slot_wide[5:0];
  assign last_o       = out_last_q;

endmodule
